// ----- hw/rtl/pipn_pkg.sv -----
// Shared widths, constants and types for the point-in-polygon nearest-edge block.
package pipn_pkg;

  localparam int COORD_W = 24;   // Q8.16 coordinates
  localparam int DIFF_W  = 25;   // difference of two coordinates
  localparam int OPND_W  = 26;   // multiplier operand
  localparam int PROD_W  = 52;   // multiplier product and small sums
  localparam int HALF_W  = 25;   // half of the cross-product magnitude
  localparam int SQ_W    = 50;   // squared distance, square root input
  localparam int DVD_W   = 100;  // squared cross product
  localparam int DIST_W  = 25;
  localparam int EDGE_W  = 12;
  localparam int THR_W   = 16;

  localparam logic [THR_W-1:0]  THR_RESET     = 16'd655;
  localparam logic [DIST_W-1:0] DIST_ALL_ONES = '1;

  typedef logic signed [DIFF_W-1:0] diff_t;
  typedef logic signed [OPND_W-1:0] opnd_t;
  typedef logic signed [PROD_W-1:0] prod_t;

endpackage

// ----- hw/rtl/pipn_mul.sv -----
// Shared signed multiplier with registered product.
module pipn_mul (
  input  logic                  clk_i,
  input  pipn_pkg::opnd_t       a_i,
  input  pipn_pkg::opnd_t       b_i,
  output pipn_pkg::prod_t       p_o
);

  pipn_pkg::prod_t p_q;

  always_ff @(posedge clk_i) begin
    p_q <= a_i * b_i;
  end

  assign p_o = p_q;

endmodule

// ----- hw/rtl/pipn_div.sv -----
// Restoring divider, one quotient bit per cycle.
module pipn_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [pipn_pkg::DVD_W-1:0]   dividend_i,
  input  logic [pipn_pkg::SQ_W-1:0]    divisor_i,
  output logic                         done_o,
  output logic [pipn_pkg::SQ_W-1:0]    quot_o
);

  localparam int CW = $clog2(pipn_pkg::DVD_W);

  logic [pipn_pkg::DVD_W-1:0] dvd_q;
  logic [pipn_pkg::SQ_W-1:0]  dsr_q;
  logic [pipn_pkg::SQ_W-1:0]  rem_q;
  logic [pipn_pkg::SQ_W-1:0]  quot_q;
  logic [CW-1:0]              cnt_q;
  logic                       run_q;
  logic                       done_q;

  logic [pipn_pkg::SQ_W:0] rem_n;
  logic [pipn_pkg::SQ_W:0] rem_s;
  logic                    ge;

  always_comb begin
    rem_n = {rem_q, dvd_q[pipn_pkg::DVD_W-1]};
    ge    = rem_n >= {1'b0, dsr_q};
    rem_s = rem_n - {1'b0, dsr_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CW'(pipn_pkg::DVD_W - 1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q  <= dividend_i;
      dsr_q  <= divisor_i;
      rem_q  <= '0;
      quot_q <= '0;
    end else if (run_q) begin
      dvd_q  <= {dvd_q[pipn_pkg::DVD_W-2:0], 1'b0};
      rem_q  <= ge ? rem_s[pipn_pkg::SQ_W-1:0] : rem_n[pipn_pkg::SQ_W-1:0];
      quot_q <= {quot_q[pipn_pkg::SQ_W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

// ----- hw/rtl/pipn_isqrt.sv -----
// Digit-by-digit integer square root, one result bit per cycle.
module pipn_isqrt (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [pipn_pkg::SQ_W-1:0]     val_i,
  output logic                          done_o,
  output logic [pipn_pkg::DIST_W-1:0]   root_o
);

  localparam int STEPS = pipn_pkg::SQ_W / 2;
  localparam int CW    = $clog2(STEPS);

  logic [pipn_pkg::SQ_W-1:0] x_q;
  logic [pipn_pkg::SQ_W-1:0] r_q;
  logic [pipn_pkg::SQ_W-1:0] bit_q;
  logic [CW-1:0]             cnt_q;
  logic                      run_q;
  logic                      done_q;

  logic [pipn_pkg::SQ_W:0] t;
  logic                    ge;

  always_comb begin
    t  = {1'b0, r_q} + {1'b0, bit_q};
    ge = {1'b0, x_q} >= t;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CW'(STEPS - 1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q   <= val_i;
      r_q   <= '0;
      bit_q <= {2'b01, {(pipn_pkg::SQ_W-2){1'b0}}};
    end else if (run_q) begin
      if (ge) begin
        x_q <= x_q - t[pipn_pkg::SQ_W-1:0];
        r_q <= (r_q >> 1) + bit_q;
      end else begin
        r_q <= r_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

  // root of a 50-bit value is below 2^25
  assign done_o = done_q;
  assign root_o = r_q[pipn_pkg::DIST_W-1:0];

endmodule

// ----- hw/rtl/point_in_polygon_nearest_edge.sv -----
// Streaming point-in-polygon test with nearest-edge distance. Vertices arrive one per
// transaction; the query point is taken from the first vertex. Every edge runs through
// one shared 26x26 multiplier under a small sequencer: six products for the crossing
// test, projection and length, then two more and the square root when the nearest
// point is an endpoint, or three more, a restoring divide and the square root when it
// lies inside the edge. A first vertex that is not also the last runs no edge; the
// last vertex also runs the closing edge and the finish state. The input is stalled
// while an edge or the finish state is in progress. One result per polygon.
module point_in_polygon_nearest_edge #(
  parameter int MAX_VERTICES = 4096
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [pipn_pkg::THR_W-1:0]        cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic signed [pipn_pkg::COORD_W-1:0] vertex_x_i,
  input  logic signed [pipn_pkg::COORD_W-1:0] vertex_y_i,
  input  logic signed [pipn_pkg::COORD_W-1:0] query_x_i,
  input  logic signed [pipn_pkg::COORD_W-1:0] query_y_i,
  input  logic                              last_vertex_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic                              accepted_o,
  output logic                              strictly_inside_o,
  output logic [pipn_pkg::EDGE_W-1:0]       nearest_edge_o,
  output logic [pipn_pkg::DIST_W-1:0]       min_distance_o
);

  localparam int CNT_W = $clog2(MAX_VERTICES + 1);

  typedef enum logic [4:0] {
    S_IDLE, S_SETUP, S_CR0, S_CR1, S_CR2, S_DOT1, S_DOT2, S_LEN1, S_LEN2, S_BR,
    S_SQ1, S_SQ2, S_M1, S_M2, S_M3, S_DIVGO, S_DIV, S_SQRT, S_FIN
  } state_e;

  state_e state_q;

  logic [pipn_pkg::THR_W-1:0] thr_q;

  logic signed [pipn_pkg::COORD_W-1:0] vx_q, vy_q, px_q, py_q;
  logic signed [pipn_pkg::COORD_W-1:0] first_x_q, first_y_q, prev_x_q, prev_y_q;
  logic                                last_q, closing_q, tie_q, use_u_q, cross_q;
  logic                                parity_q;
  logic [CNT_W-1:0]                    cnt_q;
  logic [pipn_pkg::EDGE_W-1:0]         idx_q, best_edge_q;
  logic [pipn_pkg::DIST_W-1:0]         best_q;

  pipn_pkg::diff_t ex_q, ey_q, wx_q, wy_q, ux_q, uy_q;
  pipn_pkg::prod_t acc_q, cr_q, dot_q, len2_q, m_q;
  logic [pipn_pkg::DVD_W-1:0] dvd_q;

  logic                              out_valid_q, acc_o_q, ins_o_q;
  logic [pipn_pkg::EDGE_W-1:0]       edge_o_q;
  logic [pipn_pkg::DIST_W-1:0]       dist_o_q;

  pipn_pkg::opnd_t mul_a, mul_b;
  pipn_pkg::prod_t mul_p;

  logic                              div_start, div_done;
  logic [pipn_pkg::SQ_W-1:0]         div_quot;
  logic                              sqrt_start, sqrt_done;
  logic [pipn_pkg::SQ_W-1:0]         sqrt_val;
  logic [pipn_pkg::DIST_W-1:0]       sqrt_root;

  logic signed [pipn_pkg::COORD_W-1:0] ax, ay, bx, by;
  logic [CNT_W-1:0]                    idx_full;
  pipn_pkg::prod_t                     cr_d, sum_d;
  logic [pipn_pkg::HALF_W-1:0]         m_lo, m_hi;
  logic                                cr_pos, cr_neg;

  // endpoints: A is the later vertex in loop order
  always_comb begin
    ax = closing_q ? first_x_q : vx_q;
    ay = closing_q ? first_y_q : vy_q;
    bx = closing_q ? vx_q : prev_x_q;
    by = closing_q ? vy_q : prev_y_q;
    idx_full = (cnt_q < CNT_W'(MAX_VERTICES)) ? cnt_q : CNT_W'(MAX_VERTICES - 1);
    cr_d   = acc_q - mul_p;
    sum_d  = acc_q + mul_p;
    cr_pos = !cr_d[pipn_pkg::PROD_W-1] && (cr_d != '0);
    cr_neg = cr_d[pipn_pkg::PROD_W-1];
    m_lo   = m_q[pipn_pkg::HALF_W-1:0];
    m_hi   = m_q[2*pipn_pkg::HALF_W-1:pipn_pkg::HALF_W];
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      S_CR0:  begin mul_a = pipn_pkg::OPND_W'(ex_q); mul_b = pipn_pkg::OPND_W'(wy_q); end
      S_CR1:  begin mul_a = pipn_pkg::OPND_W'(ey_q); mul_b = pipn_pkg::OPND_W'(wx_q); end
      S_CR2:  begin mul_a = pipn_pkg::OPND_W'(wx_q); mul_b = pipn_pkg::OPND_W'(ex_q); end
      S_DOT1: begin mul_a = pipn_pkg::OPND_W'(wy_q); mul_b = pipn_pkg::OPND_W'(ey_q); end
      S_DOT2: begin mul_a = pipn_pkg::OPND_W'(ex_q); mul_b = pipn_pkg::OPND_W'(ex_q); end
      S_LEN1: begin mul_a = pipn_pkg::OPND_W'(ey_q); mul_b = pipn_pkg::OPND_W'(ey_q); end
      S_BR: begin
        priority if (dot_q <= 0) begin
          mul_a = pipn_pkg::OPND_W'(wx_q);
          mul_b = pipn_pkg::OPND_W'(wx_q);
        end else if (dot_q >= len2_q) begin
          mul_a = pipn_pkg::OPND_W'(ux_q);
          mul_b = pipn_pkg::OPND_W'(ux_q);
        end else begin
          mul_a = signed'({1'b0, m_lo});
          mul_b = signed'({1'b0, m_lo});
        end
      end
      S_SQ1: begin
        mul_a = use_u_q ? pipn_pkg::OPND_W'(uy_q) : pipn_pkg::OPND_W'(wy_q);
        mul_b = mul_a;
      end
      S_M1: begin mul_a = signed'({1'b0, m_hi}); mul_b = signed'({1'b0, m_lo}); end
      S_M2: begin mul_a = signed'({1'b0, m_hi}); mul_b = signed'({1'b0, m_hi}); end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  assign div_start  = (state_q == S_DIVGO);
  assign sqrt_start = (state_q == S_SQ2) || (state_q == S_DIV && div_done);
  assign sqrt_val   = (state_q == S_SQ2) ? sum_d[pipn_pkg::SQ_W-1:0] : div_quot;

  pipn_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  pipn_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dvd_q),
    .divisor_i  (len2_q[pipn_pkg::SQ_W-1:0]),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  pipn_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start),
    .val_i   (sqrt_val),
    .done_o  (sqrt_done),
    .root_o  (sqrt_root)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= pipn_pkg::THR_RESET;
    end else if (cfg_we_i) begin
      thr_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
      parity_q    <= 1'b0;
      best_q      <= pipn_pkg::DIST_ALL_ONES;
      best_edge_q <= '0;
      closing_q   <= 1'b0;
      last_q      <= 1'b0;
      first_x_q   <= '0;
      first_y_q   <= '0;
      prev_x_q    <= '0;
      prev_y_q    <= '0;
      px_q        <= '0;
      py_q        <= '0;
    end else begin
      // the finish state drives the result valid itself
      if (out_valid_q && !out_stall_i && state_q != S_FIN) out_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            vx_q   <= vertex_x_i;
            vy_q   <= vertex_y_i;
            last_q <= last_vertex_i;
            if (cnt_q == '0) begin
              px_q      <= query_x_i;
              py_q      <= query_y_i;
              first_x_q <= vertex_x_i;
              first_y_q <= vertex_y_i;
              prev_x_q  <= vertex_x_i;
              prev_y_q  <= vertex_y_i;
              cnt_q     <= CNT_W'(1);
              closing_q <= 1'b1;
              state_q   <= last_vertex_i ? S_SETUP : S_IDLE;
            end else begin
              closing_q <= 1'b0;
              state_q   <= S_SETUP;
            end
          end
        end
        S_SETUP: begin
          ex_q    <= pipn_pkg::DIFF_W'(bx) - pipn_pkg::DIFF_W'(ax);
          ey_q    <= pipn_pkg::DIFF_W'(by) - pipn_pkg::DIFF_W'(ay);
          wx_q    <= pipn_pkg::DIFF_W'(px_q) - pipn_pkg::DIFF_W'(ax);
          wy_q    <= pipn_pkg::DIFF_W'(py_q) - pipn_pkg::DIFF_W'(ay);
          ux_q    <= pipn_pkg::DIFF_W'(px_q) - pipn_pkg::DIFF_W'(bx);
          uy_q    <= pipn_pkg::DIFF_W'(py_q) - pipn_pkg::DIFF_W'(by);
          cross_q <= (ay > py_q) != (by > py_q);
          if (closing_q) begin
            idx_q <= '0;
            tie_q <= 1'b1;
          end else begin
            idx_q    <= pipn_pkg::EDGE_W'(idx_full);
            tie_q    <= 1'b0;
            prev_x_q <= vx_q;
            prev_y_q <= vy_q;
            if (cnt_q < CNT_W'(MAX_VERTICES)) cnt_q <= cnt_q + 1'b1;
          end
          state_q <= S_CR0;
        end
        S_CR0: state_q <= S_CR1;
        S_CR1: begin
          acc_q   <= mul_p;
          state_q <= S_CR2;
        end
        S_CR2: begin
          // crossing: sign of the cross product against the sign of dy
          cr_q <= cr_d;
          if (cross_q && (ey_q > 0 ? cr_pos : cr_neg)) parity_q <= !parity_q;
          state_q <= S_DOT1;
        end
        S_DOT1: begin
          acc_q   <= mul_p;
          m_q     <= cr_q[pipn_pkg::PROD_W-1] ? -cr_q : cr_q;
          state_q <= S_DOT2;
        end
        S_DOT2: begin
          dot_q   <= sum_d;
          state_q <= S_LEN1;
        end
        S_LEN1: begin
          acc_q   <= mul_p;
          state_q <= S_LEN2;
        end
        S_LEN2: begin
          len2_q  <= sum_d;
          state_q <= S_BR;
        end
        S_BR: begin
          priority if (dot_q <= 0) begin
            use_u_q <= 1'b0;
            state_q <= S_SQ1;
          end else if (dot_q >= len2_q) begin
            use_u_q <= 1'b1;
            state_q <= S_SQ1;
          end else begin
            state_q <= S_M1;
          end
        end
        S_SQ1: begin
          acc_q   <= mul_p;
          state_q <= S_SQ2;
        end
        S_SQ2: state_q <= S_SQRT;
        S_M1: begin
          dvd_q   <= pipn_pkg::DVD_W'($unsigned(mul_p));
          state_q <= S_M2;
        end
        S_M2: begin
          dvd_q   <= dvd_q + (pipn_pkg::DVD_W'($unsigned(mul_p)) << (pipn_pkg::HALF_W + 1));
          state_q <= S_M3;
        end
        S_M3: begin
          dvd_q   <= dvd_q + (pipn_pkg::DVD_W'($unsigned(mul_p)) << (2 * pipn_pkg::HALF_W));
          state_q <= S_DIVGO;
        end
        S_DIVGO: state_q <= S_DIV;
        S_DIV: begin
          if (div_done) state_q <= S_SQRT;
        end
        S_SQRT: begin
          if (sqrt_done) begin
            if (sqrt_root < best_q || (tie_q && sqrt_root == best_q)) begin
              best_q      <= sqrt_root;
              best_edge_q <= idx_q;
            end
            priority if (closing_q) begin
              state_q <= S_FIN;
            end else if (last_q) begin
              closing_q <= 1'b1;
              state_q   <= S_SETUP;
            end else begin
              state_q <= S_IDLE;
            end
          end
        end
        S_FIN: begin
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q <= 1'b1;
            acc_o_q     <= parity_q || (best_q <= pipn_pkg::DIST_W'(thr_q));
            ins_o_q     <= parity_q;
            edge_o_q    <= best_edge_q;
            dist_o_q    <= best_q;
            parity_q    <= 1'b0;
            best_q      <= pipn_pkg::DIST_ALL_ONES;
            best_edge_q <= '0;
            cnt_q       <= '0;
            closing_q   <= 1'b0;
            first_x_q   <= '0;
            first_y_q   <= '0;
            prev_x_q    <= '0;
            prev_y_q    <= '0;
            px_q        <= '0;
            py_q        <= '0;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_stall_o        = (state_q != S_IDLE);
  assign out_valid_o       = out_valid_q;
  assign accepted_o        = acc_o_q;
  assign strictly_inside_o = ins_o_q;
  assign nearest_edge_o    = edge_o_q;
  assign min_distance_o    = dist_o_q;

  a_out_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == S_FIN))
    else $error("result raised outside finish state");

  a_div_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == S_DIV)
    else $error("divider finished while sequencer not waiting");

  a_sqrt_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sqrt_done |-> state_q == S_SQRT)
    else $error("square root finished while sequencer not waiting");

endmodule

// ----- tb/sv/point_in_polygon_nearest_edge_checker.sv -----
// Checker: watches both channels, predicts each polygon result and compares it.
`timescale 1ns / 100ps
module point_in_polygon_nearest_edge_checker (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [pipn_pkg::THR_W-1:0]          cfg_data_i,
  input  logic                                in_valid_i,
  input  logic                                in_stall_i,
  input  logic signed [pipn_pkg::COORD_W-1:0] vertex_x_i,
  input  logic signed [pipn_pkg::COORD_W-1:0] vertex_y_i,
  input  logic signed [pipn_pkg::COORD_W-1:0] query_x_i,
  input  logic signed [pipn_pkg::COORD_W-1:0] query_y_i,
  input  logic                                last_vertex_i,
  input  logic                                out_valid_i,
  input  logic                                out_stall_i,
  input  logic                                accepted_i,
  input  logic                                strictly_inside_i,
  input  logic [pipn_pkg::EDGE_W-1:0]         nearest_edge_i,
  input  logic [pipn_pkg::DIST_W-1:0]         min_distance_i,
  output int                                  fail_count_o,
  output int                                  pending_o
);

  localparam int MAX_VERTS = 4096;

  typedef struct packed {
    logic                          accepted;
    logic                          in_poly;
    logic [pipn_pkg::EDGE_W-1:0]   nearest;
    logic [pipn_pkg::DIST_W-1:0]   distance;
  } poly_result_t;

  poly_result_t                expected_polys[$];
  logic [pipn_pkg::THR_W-1:0]  thr;
  longint                      first_x, first_y, prev_x, prev_y, pt_x, pt_y;
  logic                        parity;
  logic [pipn_pkg::DIST_W-1:0] best_dist;
  logic [pipn_pkg::EDGE_W-1:0] best_idx;
  int                          vert_cnt;
  int                          fails;

  assign fail_count_o = fails;
  assign pending_o    = expected_polys.size();

  function automatic logic [127:0] isqrt(logic [127:0] x);
    logic [127:0] r, b;
    r = '0;
    b = 128'd1 << 126;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic [pipn_pkg::DIST_W-1:0] segment_distance(longint ax, longint ay,
                                                                   longint bx, longint by);
    longint       ex, ey, wx, wy, dot, len2, cr, ux, uy;
    logic [127:0] r, m;
    ex = bx - ax;  ey = by - ay;
    wx = pt_x - ax; wy = pt_y - ay;
    dot  = wx * ex + wy * ey;
    len2 = ex * ex + ey * ey;
    if (dot <= 0) begin
      r = isqrt(128'(wx * wx + wy * wy));
    end else if (dot >= len2) begin
      ux = pt_x - bx; uy = pt_y - by;
      r = isqrt(128'(ux * ux + uy * uy));
    end else begin
      cr = ex * wy - ey * wx;
      if (cr < 0) cr = -cr;
      m = 128'(cr);
      r = isqrt((m * m) / 128'(len2));
    end
    return (r > 128'(pipn_pkg::DIST_ALL_ONES)) ? pipn_pkg::DIST_ALL_ONES
                                                : r[pipn_pkg::DIST_W-1:0];
  endfunction

  // (xi, yi) is the later vertex of the edge in loop order
  task automatic run_edge(longint xi, longint yi, longint xj, longint yj,
                          logic [pipn_pkg::EDGE_W-1:0] idx, bit tie_wins);
    longint                      dy, lhs, rhs;
    logic [pipn_pkg::DIST_W-1:0] d;
    if ((yi > pt_y) != (yj > pt_y)) begin
      dy  = yj - yi;
      lhs = (pt_x - xi) * dy;
      rhs = (xj - xi) * (pt_y - yi);
      if (dy > 0 ? (lhs < rhs) : (lhs > rhs)) parity = ~parity;
    end
    d = segment_distance(xi, yi, xj, yj);
    if (d < best_dist || (tie_wins && d == best_dist)) begin
      best_dist = d;
      best_idx  = idx;
    end
  endtask

  task automatic clear_polygon();
    first_x = 0; first_y = 0; prev_x = 0; prev_y = 0; pt_x = 0; pt_y = 0;
    parity = 1'b0; best_dist = pipn_pkg::DIST_ALL_ONES; best_idx = '0; vert_cnt = 0;
  endtask

  task automatic take_vertex();
    longint       vx, vy;
    poly_result_t res;
    vx = longint'(vertex_x_i);
    vy = longint'(vertex_y_i);
    if (vert_cnt == 0) begin
      pt_x = longint'(query_x_i); pt_y = longint'(query_y_i);
      first_x = vx; first_y = vy;
    end else begin
      run_edge(vx, vy, prev_x, prev_y,
               pipn_pkg::EDGE_W'(vert_cnt < MAX_VERTS ? vert_cnt : MAX_VERTS - 1), 1'b0);
    end
    prev_x = vx; prev_y = vy;
    if (vert_cnt < MAX_VERTS) vert_cnt++;
    if (last_vertex_i) begin
      run_edge(first_x, first_y, vx, vy, '0, 1'b1);
      res.accepted = parity || (best_dist <= pipn_pkg::DIST_W'(thr));
      res.in_poly  = parity;
      res.nearest  = best_idx;
      res.distance = best_dist;
      expected_polys.push_back(res);
      clear_polygon();
    end
  endtask

  task automatic check_result();
    poly_result_t exp_r, got;
    got = '{accepted_i, strictly_inside_i, nearest_edge_i, min_distance_i};
    if (expected_polys.size() == 0) begin
      fails++;
      if (fails <= 10) $display("unexpected result transaction: %p", got);
    end else begin
      exp_r = expected_polys.pop_front();
      if (got !== exp_r) begin
        fails++;
        if (fails <= 10)
          $display("result mismatch: exp acc=%0b in=%0b edge=%0d dist=%0d, %s",
                   exp_r.accepted, exp_r.in_poly, exp_r.nearest, exp_r.distance,
                   $sformatf("got acc=%0b in=%0b edge=%0d dist=%0d",
                             got.accepted, got.in_poly, got.nearest, got.distance));
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr = pipn_pkg::THR_RESET;
      clear_polygon();
      expected_polys.delete();
      fails = 0;
    end else begin
      if (cfg_we_i) thr = cfg_data_i;
      if (in_valid_i && !in_stall_i) take_vertex();
      if (out_valid_i && !out_stall_i) check_result();
    end
  end

endmodule

// ----- tb/sv/point_in_polygon_nearest_edge_tb.sv -----
// Testbench top: drives polygons and register writes, gives the verdict.
`timescale 1ns / 100ps
module point_in_polygon_nearest_edge_tb;

  localparam int CYCLE_LIMIT   = 4000000;
  localparam int SETTLE_CYCLES = 400;
  localparam int HOLD_CYCLES   = 3000;

  logic                                clk_i = 1'b0;
  logic                                rst_ni = 1'b0;
  logic                                cfg_we = 1'b0;
  logic [pipn_pkg::THR_W-1:0]          cfg_data = '0;
  logic                                in_valid = 1'b0;
  logic                                in_stall;
  logic signed [pipn_pkg::COORD_W-1:0] vx = '0, vy = '0, qx = '0, qy = '0;
  logic                                last_v = 1'b0;
  logic                                out_valid;
  logic                                out_stall = 1'b0;
  logic                                accepted, strictly_inside;
  logic [pipn_pkg::EDGE_W-1:0]         nearest;
  logic [pipn_pkg::DIST_W-1:0]         min_dist;
  int                                  fail_count, pending;
  int                                  cycles = 0;
  int                                  items = 0;
  bit                                  quiet = 1'b0;
  bit                                  hold_req = 1'b0;

  always #2 clk_i = ~clk_i;

  point_in_polygon_nearest_edge DUT (
    .clk_i, .rst_ni,
    .cfg_we_i(cfg_we), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .vertex_x_i(vx), .vertex_y_i(vy), .query_x_i(qx), .query_y_i(qy),
    .last_vertex_i(last_v),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .accepted_o(accepted), .strictly_inside_o(strictly_inside),
    .nearest_edge_o(nearest), .min_distance_o(min_dist)
  );

  point_in_polygon_nearest_edge_checker u_checker (
    .clk_i, .rst_ni,
    .cfg_we_i(cfg_we), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_stall_i(in_stall),
    .vertex_x_i(vx), .vertex_y_i(vy), .query_x_i(qx), .query_y_i(qy),
    .last_vertex_i(last_v),
    .out_valid_i(out_valid), .out_stall_i(out_stall),
    .accepted_i(accepted), .strictly_inside_i(strictly_inside),
    .nearest_edge_i(nearest), .min_distance_i(min_dist),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // result side: random stall bursts, plus one long hold-off on request
  initial begin : result_stall
    int burst;
    int hold;
    burst = 0;
    hold  = 0;
    forever begin
      @(negedge clk_i);
      if (hold_req && hold == 0) begin
        hold = HOLD_CYCLES;
        hold_req = 1'b0;
      end
      if (hold > 0) begin
        hold--;
        out_stall = 1'b1;
      end else if (burst > 0) begin
        burst--;
        out_stall = 1'b1;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        burst = $urandom_range(0, 5);
        out_stall = 1'b1;
      end else begin
        out_stall = 1'b0;
      end
    end
  end

  // one vertex transaction; called right after a falling edge
  task automatic send_vertex(int x, int y, int px, int py, bit last);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end
    vx = x[pipn_pkg::COORD_W-1:0]; vy = y[pipn_pkg::COORD_W-1:0];
    qx = px[pipn_pkg::COORD_W-1:0]; qy = py[pipn_pkg::COORD_W-1:0];
    last_v = last;
    in_valid = 1'b1;
    do @(posedge clk_i); while (in_stall);
    @(negedge clk_i);
    items++;
  endtask

  task automatic write_threshold(int value);
    in_valid = 1'b0;
    wait (pending == 0);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    cfg_we = 1'b1;
    cfg_data = value[pipn_pkg::THR_W-1:0];
    @(negedge clk_i);
    cfg_we = 1'b0;
  endtask

  task automatic unit_square(int px, int py);
    send_vertex(0, 0, px, py, 1'b0);
    send_vertex(65536, 0, $urandom, $urandom, 1'b0);
    send_vertex(65536, 65536, $urandom, $urandom, 1'b0);
    send_vertex(0, 65536, $urandom, $urandom, 1'b1);
  endtask

  // random polygon; spread picks how far vertices and query point sit from a random centre
  task automatic random_polygon(int nverts, int spread);
    int cx, cy, px, py, x, y;
    cx = $urandom_range(0, 8000000) - 4000000;
    cy = $urandom_range(0, 8000000) - 4000000;
    px = cx + $urandom_range(0, 2 * spread) - spread;
    py = cy + $urandom_range(0, 2 * spread) - spread;
    for (int k = 0; k < nverts; k++) begin
      if (spread == 0) begin
        x = $urandom; y = $urandom;
      end else begin
        x = cx + $urandom_range(0, 2 * spread) - spread;
        y = cy + $urandom_range(0, 2 * spread) - spread;
      end
      if (k == 0) send_vertex(x, y, px, py, nverts == 1);
      else send_vertex(x, y, $urandom, $urandom, k == nverts - 1);
    end
  endtask

  task automatic random_phase(int count);
    int spread, n, target;
    target = items + count;
    while (items < target) begin
      case ($urandom_range(0, 9))
        0, 1:    spread = 0;
        2, 3:    spread = 4;
        4, 5, 6: spread = 800;
        default: spread = 200000;
      endcase
      n = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 9);
      random_polygon(n, spread);
    end
  endtask

  initial begin : stimulus
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // point at center of a square: every edge ties, closing edge must win
    unit_square(32768, 32768);
    // single vertex polygon at the coordinate extremes
    send_vertex(8388607, -8388608, -8388608, 8388607, 1'b1);
    // zero-length edge
    send_vertex(100, 100, 100, 300, 1'b0);
    send_vertex(100, 100, 0, 0, 1'b0);
    send_vertex(5000, 200, 0, 0, 1'b1);
    // point on a horizontal edge
    send_vertex(0, 0, 500, 0, 1'b0);
    send_vertex(1000, 0, 0, 0, 1'b0);
    send_vertex(0, 1000, 0, 0, 1'b1);
    // just outside, within the reset tolerance
    unit_square(-600, 30000);
    write_threshold(0);
    unit_square(-1, 30000);
    write_threshold(65535);
    unit_square(-65535, 30000);
    write_threshold($urandom_range(0, 65535));

    random_phase(500);
    write_threshold(0);
    // long hold-off on the result side while vertices keep coming
    hold_req = 1'b1;
    random_phase(300);
    write_threshold(65535);
    random_phase(500);
    write_threshold($urandom_range(1, 65534));
    random_phase(400);
    write_threshold(655);
    quiet = 1'b1;
    random_phase(300);

    in_valid = 1'b0;
    wait (pending == 0);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
